FILE: design/acc_pkg.sv
package acc_pkg;

    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] ENGAGE_MIN_SPEED = 16'd2816;
    localparam logic [7:0]  SET_SPEED_RESET  = 8'd40;
    localparam logic [7:0]  SET_SPEED_LOW    = 8'd40;
    localparam logic [7:0]  SET_SPEED_HIGH   = 8'd120;
    localparam logic [14:0] MIN_DIST         = 15'd160;

    localparam logic signed [11:0] ACC_MIN   = -12'sd1280;
    localparam logic signed [11:0] ACC_MAX   = 12'sd376;
    localparam logic [11:0]        ACC_BIAS  = 12'd1280;

    // law terms kept in 1/100 LSB; rounding bias and saturation thresholds
    localparam logic signed [23:0] ROUND_BIAS = 24'sd50;
    localparam logic signed [23:0] SAT_LO_B   = -24'sd128000;
    localparam logic signed [23:0] SAT_HI_B   = 24'sd37700;
    localparam logic signed [23:0] DIV_OFFSET = 24'sd128000;

    // floor(u / 100) = (u * RECIP_100) >> RECIP_SHIFT, exact for u below 199700
    localparam logic [17:0] RECIP_100   = 18'd167773;
    localparam int unsigned RECIP_SHIFT = 24;

    typedef struct packed {
        logic               engaged;
        logic               rain;
        logic [15:0]        ego_speed;
        logic signed [15:0] relative_speed;
        logic [15:0]        relative_distance;
    } acc_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } acc_fifo_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIST,
        BK_LAW,
        BK_DIV,
        BK_OUT
    } acc_back_state_t;

endpackage

FILE: design/acc_front.sv
module acc_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_engage_request,
    input  logic                      s_fault,
    input  logic                      s_gas_pressed,
    input  logic                      s_brake_pressed,
    input  logic                      s_rain,
    input  logic [15:0]               s_ego_speed,
    input  logic signed [15:0]        s_relative_speed,
    input  logic [15:0]               s_relative_distance,
    input  acc_pkg::acc_fifo_status_t fifo_status,
    output logic                      push,
    output acc_pkg::acc_entry_t       push_entry
);
    import acc_pkg::*;

    logic latch_reg;
    logic latch_next;

    assign s_ready = !fifo_status.full;
    assign push    = s_valid && s_ready;

    assign latch_next = s_engage_request && !s_fault && !s_gas_pressed && !s_brake_pressed
                        && (latch_reg || (s_ego_speed >= ENGAGE_MIN_SPEED));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg <= 1'b0;
        end else if (push) begin
            latch_reg <= latch_next;
        end
    end

    always_comb begin
        push_entry.engaged           = latch_next;
        push_entry.rain              = s_rain;
        push_entry.ego_speed         = s_ego_speed;
        push_entry.relative_speed    = s_relative_speed;
        push_entry.relative_distance = s_relative_distance;
    end

endmodule

FILE: design/acc_fifo.sv
module acc_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  acc_pkg::acc_entry_t       push_entry,
    input  logic                      pop,
    output acc_pkg::acc_entry_t       pop_entry,
    output acc_pkg::acc_fifo_status_t status
);
    import acc_pkg::*;

    acc_entry_t            mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign status.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_entry    = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        status.full && !pop |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

FILE: design/acc_back.sv
module acc_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic [7:0]                cfg_data,
    input  acc_pkg::acc_fifo_status_t fifo_status,
    input  acc_pkg::acc_entry_t       pop_entry,
    output logic                      pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_engaged,
    output logic signed [11:0]        m_acceleration,
    output logic [14:0]               m_safe_gap
);
    import acc_pkg::*;

    acc_back_state_t state_reg;
    acc_back_state_t state_next;

    logic [7:0]         set_speed_reg;
    acc_entry_t         work_reg;
    logic [14:0]        safe_reg;
    logic signed [17:0] d_reg;
    logic signed [23:0] v_reg;
    logic [17:0]        u_reg;
    logic               sat_lo_reg;
    logic               sat_hi_reg;
    logic [35:0]        prod_reg;

    logic               m_valid_reg;
    logic               m_engaged_reg;
    logic signed [11:0] m_accel_reg;
    logic [14:0]        m_safe_reg;

    logic               out_free;
    logic               out_load;

    // distance stage
    logic [7:0]         sp_clamped;
    logic [17:0]        ego_x3;
    logic [18:0]        ego_gap;
    logic [14:0]        safe_calc;
    logic signed [17:0] d_calc;
    logic signed [16:0] speed_err;
    logic signed [23:0] speed_err_ext;
    logic signed [23:0] v_calc;

    // law stage
    logic signed [23:0] rv_ext;
    logic signed [23:0] d_ext;
    logic signed [23:0] x_calc;
    logic signed [23:0] a_calc;
    logic signed [23:0] b_calc;
    logic signed [23:0] u_calc;

    // output stage
    logic [11:0]        q_calc;
    logic signed [11:0] accel_calc;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!fifo_status.empty) state_next = BK_DIST;
            BK_DIST: state_next = BK_LAW;
            BK_LAW:  state_next = BK_DIV;
            BK_DIV:  state_next = BK_OUT;
            BK_OUT: begin
                if (out_free) begin
                    state_next = fifo_status.empty ? BK_IDLE : BK_DIST;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            BK_IDLE: pop = !fifo_status.empty;
            BK_OUT: begin
                out_load = out_free;
                pop      = out_free && !fifo_status.empty;
            end
            default: begin
                pop      = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (set_speed_reg > SET_SPEED_HIGH) begin
            sp_clamped = SET_SPEED_HIGH;
        end else if (set_speed_reg < SET_SPEED_LOW) begin
            sp_clamped = SET_SPEED_LOW;
        end else begin
            sp_clamped = set_speed_reg;
        end
        ego_x3        = {1'b0, work_reg.ego_speed, 1'b0} + {2'b00, work_reg.ego_speed};
        ego_gap       = work_reg.rain ? {ego_x3, 1'b0} : {1'b0, ego_x3};
        safe_calc     = ego_gap[18:4] + MIN_DIST;
        d_calc        = $signed({3'b000, safe_calc}) - $signed({2'b00, work_reg.relative_distance});
        speed_err     = $signed({1'b0, sp_clamped, 8'h00}) - $signed({1'b0, work_reg.ego_speed});
        speed_err_ext = 24'(speed_err);
        v_calc        = (speed_err_ext <<< 5) + (speed_err_ext <<< 4) + (speed_err_ext <<< 1);
    end

    always_comb begin
        rv_ext = 24'(work_reg.relative_speed);
        d_ext  = 24'(d_reg);
        x_calc = (rv_ext <<< 2) - (d_ext <<< 5);
        if (d_reg > 18'sd0) begin
            a_calc = x_calc;
        end else begin
            a_calc = (x_calc < v_reg) ? x_calc : v_reg;
        end
        b_calc = a_calc + ROUND_BIAS;
        u_calc = b_calc + DIV_OFFSET;
    end

    always_comb begin
        q_calc = prod_reg[RECIP_SHIFT +: 12];
        priority if (sat_lo_reg) begin
            accel_calc = ACC_MIN;
        end else if (sat_hi_reg) begin
            accel_calc = ACC_MAX;
        end else begin
            accel_calc = $signed(q_calc - ACC_BIAS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            set_speed_reg <= SET_SPEED_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                set_speed_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            work_reg <= pop_entry;
        end
        if (state_reg == BK_DIST) begin
            safe_reg <= safe_calc;
            d_reg    <= d_calc;
            v_reg    <= v_calc;
        end
        if (state_reg == BK_LAW) begin
            sat_lo_reg <= (b_calc < SAT_LO_B);
            sat_hi_reg <= (b_calc >= SAT_HI_B);
            u_reg      <= u_calc[17:0];
        end
        if (state_reg == BK_DIV) begin
            prod_reg <= u_reg * RECIP_100;
        end
        if (out_load) begin
            m_engaged_reg <= work_reg.engaged;
            m_accel_reg   <= work_reg.engaged ? accel_calc : '0;
            m_safe_reg    <= work_reg.engaged ? safe_reg : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_engaged      = m_engaged_reg;
    assign m_acceleration = m_accel_reg;
    assign m_safe_gap     = m_safe_reg;

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_engaged_reg |-> m_accel_reg == '0 && m_safe_reg == '0)
        else $error("disengaged word carries nonzero payload");

    a_accel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_accel_reg >= ACC_MIN && m_accel_reg <= ACC_MAX)
        else $error("acceleration out of range");

    a_pop_start: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> state_reg == BK_DIST)
        else $error("pop did not start computation");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !out_load)
        else $error("result overwritten while stalled");

endmodule

FILE: design/adaptive_cruise_controller.sv
// A 2-entry queue decouples the front from the four-step back-end sequencer
// (distance, law, reciprocal multiply, output), which works on one word at a time
// and holds in the output step while the result side is not ready.
// Reset (aresetn low, synchronous): engage latch cleared, queue emptied,
// set_speed back to 40, no result pending.
module adaptive_cruise_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_engage_request,
    input  logic               s_fault,
    input  logic               s_gas_pressed,
    input  logic               s_brake_pressed,
    input  logic               s_rain,
    input  logic [15:0]        s_ego_speed,
    input  logic signed [15:0] s_relative_speed,
    input  logic [15:0]        s_relative_distance,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_engaged,
    output logic signed [11:0] m_acceleration,
    output logic [14:0]        m_safe_gap
);
    import acc_pkg::*;

    acc_fifo_status_t fifo_status;
    acc_entry_t       push_entry;
    acc_entry_t       pop_entry;
    logic             push;
    logic             pop;

    assign cfg_ready = 1'b1;

    acc_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_engage_request   (s_engage_request),
        .s_fault            (s_fault),
        .s_gas_pressed      (s_gas_pressed),
        .s_brake_pressed    (s_brake_pressed),
        .s_rain             (s_rain),
        .s_ego_speed        (s_ego_speed),
        .s_relative_speed   (s_relative_speed),
        .s_relative_distance(s_relative_distance),
        .fifo_status        (fifo_status),
        .push               (push),
        .push_entry         (push_entry)
    );

    acc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .pop_entry (pop_entry),
        .status    (fifo_status)
    );

    acc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .fifo_status   (fifo_status),
        .pop_entry     (pop_entry),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_engaged     (m_engaged),
        .m_acceleration(m_acceleration),
        .m_safe_gap    (m_safe_gap)
    );

endmodule
